// ----- hw/rtl/vde_pkg.sv -----
package vde_pkg;

    localparam int ELEM_W          = 16;
    localparam int WEIGHT_W        = 16;
    localparam int SUM_W           = 48;
    localparam int MODE_W          = 3;
    localparam int TERM_W          = 40;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef logic [MODE_W-1:0] t_mode;

    localparam t_mode MODE_CITY = 3'd0;
    localparam t_mode MODE_EUCL = 3'd1;
    localparam t_mode MODE_COS  = 3'd2;
    localparam t_mode MODE_WL1  = 3'd3;
    localparam t_mode MODE_WL2  = 3'd4;
    localparam t_mode MODE_NDOT = 3'd5;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 48'sh8000_0000_0000;

    // One vector's worth of accumulated sums, handed from front to back.
    typedef struct packed {
        t_mode                    mode;
        logic signed [SUM_W-1:0]  main_sum;
        logic        [SUM_W-1:0]  norm_a;
        logic        [SUM_W-1:0]  norm_b;
    } t_vec_sums;

endpackage

// ----- hw/rtl/vde_queue.sv -----
module vde_queue
    import vde_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  t_vec_sums                    i_data,
    input  logic                         i_pop,
    output t_vec_sums                    o_data,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    t_vec_sums          r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_count;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH-1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

// ----- hw/rtl/vde_front.sv -----
module vde_front
    import vde_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [ELEM_W-1:0]           i_elem_a,
    input  logic signed [ELEM_W-1:0]           i_elem_b,
    input  logic        [WEIGHT_W-1:0]         i_weight,
    input  logic                               i_last_element,
    input  t_mode                              i_mode,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   i_q_count,
    output logic                               o_push,
    output t_vec_sums                          o_push_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

    // Stage 1: registered beat.
    logic                       r_v1, r_l1;
    logic signed [ELEM_W-1:0]   r_a1, r_b1;
    logic [WEIGHT_W-1:0]        r_w1;
    t_mode                      r_m1;
    // Stage 2: products.
    logic                       r_v2, r_l2;
    logic [16:0]                r_ad2;
    logic [33:0]                r_dd2;
    logic signed [31:0]         r_ab2;
    logic [31:0]                r_aa2, r_bb2;
    logic [WEIGHT_W-1:0]        r_w2;
    t_mode                      r_m2;
    // Stage 3: term ready to accumulate.
    logic                       r_v3, r_l3;
    logic signed [TERM_W-1:0]   r_t3;
    logic [31:0]                r_aa3, r_bb3;
    t_mode                      r_m3;
    // Accumulators.
    logic signed [SUM_W-1:0]    r_main, r_na, r_nb;

    logic [CNT_W+1:0]           claims;
    logic                       accept;
    logic signed [16:0]         d;
    logic [16:0]                ad;
    logic signed [33:0]         dd_s;
    logic [32:0]                p_wl1;
    logic [49:0]                p_wl2;
    logic signed [48:0]         p_nd;
    logic signed [TERM_W-1:0]   term;
    logic signed [SUM_W-1:0]    n_main, n_na, n_nb;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]  s,
        input logic signed [TERM_W-1:0] t
    );
        logic signed [SUM_W:0] r;
        r = {s[SUM_W-1], s} + {{(SUM_W+1-TERM_W){t[TERM_W-1]}}, t};
        if (r[SUM_W] != r[SUM_W-1]) begin
            return r[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        return r[SUM_W-1:0];
    endfunction

    // Every last beat in flight owns a queue slot, so a finished vector never stalls.
    assign claims = (CNT_W+2)'(i_q_count) + (CNT_W+2)'(r_v1 & r_l1)
                  + (CNT_W+2)'(r_v2 & r_l2) + (CNT_W+2)'(r_v3 & r_l3);
    assign o_ready = (claims < (CNT_W+2)'(QUEUE_DEPTH));
    assign accept  = i_valid && o_ready;

    assign d    = {r_a1[ELEM_W-1], r_a1} - {r_b1[ELEM_W-1], r_b1};
    assign ad   = d[16] ? 17'(-d) : 17'(d);
    assign dd_s = d * d;

    assign p_wl1 = r_ad2 * r_w2;
    assign p_wl2 = r_dd2 * r_w2;
    assign p_nd  = r_ab2 * $signed({1'b0, r_w2});

    always_comb begin
        unique case (r_m2)
            MODE_EUCL: term = TERM_W'($signed({1'b0, r_dd2}));
            MODE_COS:  term = TERM_W'(r_ab2);
            MODE_WL1:  term = TERM_W'($signed({1'b0, p_wl1[32:12]}));
            MODE_WL2:  term = TERM_W'($signed({1'b0, p_wl2[49:12]}));
            MODE_NDOT: term = TERM_W'(p_nd >>> 12);
            default:   term = TERM_W'($signed({1'b0, r_ad2}));
        endcase
    end

    assign n_main = sat_add(r_main, r_t3);
    assign n_na   = sat_add(r_na, TERM_W'($signed({1'b0, r_aa3})));
    assign n_nb   = sat_add(r_nb, TERM_W'($signed({1'b0, r_bb3})));

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a1 <= i_elem_a;
            r_b1 <= i_elem_b;
            r_w1 <= i_weight;
            r_l1 <= i_last_element;
            r_m1 <= i_mode;
        end
        r_ad2 <= ad;
        r_dd2 <= 34'(dd_s);
        r_ab2 <= r_a1 * r_b1;
        r_aa2 <= 32'(r_a1 * r_a1);
        r_bb2 <= 32'(r_b1 * r_b1);
        r_w2  <= r_w1;
        r_l2  <= r_l1;
        r_m2  <= r_m1;
        r_t3  <= term;
        r_aa3 <= r_aa2;
        r_bb3 <= r_bb2;
        r_l3  <= r_l2;
        r_m3  <= r_m2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_main <= '0;
            r_na   <= '0;
            r_nb   <= '0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_v3) begin
                if (r_l3) begin
                    r_main <= '0;
                    r_na   <= '0;
                    r_nb   <= '0;
                end else begin
                    r_main <= n_main;
                    r_na   <= n_na;
                    r_nb   <= n_nb;
                end
            end
        end
    end

    assign o_push               = r_v3 && r_l3;
    assign o_push_data.mode     = r_m3;
    assign o_push_data.main_sum = n_main;
    assign o_push_data.norm_a   = n_na;
    assign o_push_data.norm_b   = n_nb;

endmodule

// ----- hw/rtl/vde_isqrt.sv -----
module vde_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy, r_done;
    logic [63:0] r_v, r_r, r_bit;
    logic [4:0]  r_cnt;
    logic [63:0] trial;

    assign trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_r   <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
            r_cnt <= '0;
        end else if (r_busy) begin
            if (r_v >= trial) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'd31) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[31:0];

endmodule

// ----- hw/rtl/vde_back.sv -----
module vde_back
    import vde_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    input  t_vec_sums                 i_data,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [SUM_W-1:0]   o_distance,
    output logic                      o_zero_norm
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SQM  = 8'b0000_0010,
        S_SQA  = 8'b0000_0100,
        S_SQB  = 8'b0000_1000,
        S_CMP  = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_FIN  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state                   r_state;
    t_vec_sums                r_entry;
    logic [31:0]              r_ra;
    logic [63:0]              r_den;
    logic [64:0]              r_rem;
    logic [31:0]              r_q;
    logic [4:0]               r_cnt;
    logic signed [SUM_W-1:0]  r_dist;
    logic                     r_zero;

    logic                     sq_start, sq_done;
    logic [63:0]              sq_value;
    logic [31:0]              sq_root;
    logic [SUM_W-1:0]         num;
    logic [64:0]              shifted;
    logic [16:0]              qc;
    logic [18:0]              cd;

    vde_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (sq_value),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    always_comb begin
        sq_start = 1'b0;
        sq_value = {i_data.norm_a, 16'b0};
        if (r_state == S_IDLE && !i_empty) begin
            if (i_data.mode == MODE_EUCL || i_data.mode == MODE_WL2) begin
                sq_start = !i_data.main_sum[SUM_W-1] && (i_data.main_sum != '0);
                sq_value = {16'b0, i_data.main_sum};
            end else if (i_data.mode == MODE_COS) begin
                sq_start = (i_data.norm_a != '0) && (i_data.norm_b != '0);
            end
        end else if (r_state == S_SQA && sq_done) begin
            sq_start = 1'b1;
            sq_value = {r_entry.norm_b, 16'b0};
        end
    end

    assign num     = r_entry.main_sum[SUM_W-1] ? SUM_W'(-r_entry.main_sum)
                                               : SUM_W'(r_entry.main_sum);
    assign shifted = {r_rem[63:0], 1'b0};
    assign qc      = (r_q > 32'd65536) ? 17'd65536 : r_q[16:0];
    // Cosine distance is one minus the signed, clamped cosine.
    assign cd      = r_entry.main_sum[SUM_W-1] ? (19'd65536 + 19'(qc))
                                               : (19'd65536 - 19'(qc));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_entry <= i_data;
                        // A zero-length vector in cosine mode skips the roots.
                        r_zero  <= (i_data.mode == MODE_COS) && !sq_start;
                        if (i_data.mode == MODE_EUCL || i_data.mode == MODE_WL2) begin
                            if (sq_start) begin
                                r_state <= S_SQM;
                            end else begin
                                r_dist  <= '0;
                                r_state <= S_OUT;
                            end
                        end else if (i_data.mode == MODE_COS) begin
                            if (sq_start) begin
                                r_state <= S_SQA;
                            end else begin
                                r_dist  <= '0;
                                r_state <= S_OUT;
                            end
                        end else if (i_data.mode == MODE_NDOT) begin
                            r_dist  <= (i_data.main_sum == SUM_MIN) ? SUM_MAX
                                                                    : -i_data.main_sum;
                            r_state <= S_OUT;
                        end else begin
                            r_dist  <= i_data.main_sum;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_SQM: begin
                    if (sq_done) begin
                        r_dist  <= SUM_W'({16'b0, sq_root});
                        r_state <= S_OUT;
                    end
                end
                S_SQA: begin
                    if (sq_done) begin
                        r_ra    <= sq_root;
                        r_state <= S_SQB;
                    end
                end
                S_SQB: begin
                    if (sq_done) begin
                        r_den   <= r_ra * sq_root;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if ({16'b0, num} >= r_den) begin
                        r_q     <= 32'd65536;
                        r_state <= S_FIN;
                    end else begin
                        r_rem   <= {17'b0, num};
                        r_q     <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (shifted >= {1'b0, r_den}) begin
                        r_rem <= shifted - {1'b0, r_den};
                        r_q   <= {r_q[30:0], 1'b1};
                    end else begin
                        r_rem <= shifted;
                        r_q   <= {r_q[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd31) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_dist  <= SUM_W'({29'b0, cd});
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = (r_state == S_OUT);
    assign o_distance  = r_dist;
    assign o_zero_norm = r_zero;

endmodule

// ----- hw/rtl/vector_distance_engine_core.sv -----
// Channel  Handshake                 Payload
// input    i_in_valid / o_in_ready   i_elem_a, i_elem_b, i_weight, i_last_element
// output   o_out_valid / i_out_ready o_distance, o_zero_norm
// config   psel, penable, pwrite     paddr, pwdata, prdata (distance_mode at 0)
//
// The front takes one element beat per cycle, unless stalled, through a three-stage
// product and accumulate pipeline; the back finishes square-root and cosine modes with
// the shared 32-step square-root unit, and cosine also with the 32-step divider.
// The front stalls only when the result queue has no slot for a last beat in flight.
// Reset is synchronous, active low, and clears the mode and all sums.
module vector_distance_engine_core
    import vde_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [ELEM_W-1:0]  i_elem_a,
    input  logic signed [ELEM_W-1:0]  i_elem_b,
    input  logic [WEIGHT_W-1:0]       i_weight,
    input  logic                      i_last_element,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [SUM_W-1:0]   o_distance,
    output logic                      o_zero_norm,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam logic REG_MODE = 1'b0;

    t_mode                              r_mode;
    logic                               push, pop, q_empty;
    t_vec_sums                          push_data, head;
    logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_count;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MODE) ? {29'b0, r_mode} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CITY;
        end else if (psel && penable && pwrite && paddr[2] == REG_MODE) begin
            r_mode <= pwdata[MODE_W-1:0];
        end
    end

    vde_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_elem_a       (i_elem_a),
        .i_elem_b       (i_elem_b),
        .i_weight       (i_weight),
        .i_last_element (i_last_element),
        .i_mode         (r_mode),
        .i_q_count      (q_count),
        .o_push         (push),
        .o_push_data    (push_data)
    );

    vde_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (head),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    vde_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_data      (head),
        .o_pop       (pop),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_distance  (o_distance),
        .o_zero_norm (o_zero_norm)
    );

`ifndef SYNTH
    a_zero_norm_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_norm |-> o_distance == '0)
        else $error("zero_norm result with nonzero distance");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |-> q_count < QUEUE_DEPTH)
        else $error("result queue overflow");

    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_mode == MODE_COS |-> o_distance >= 0 && o_distance <= 131072)
        else $error("cosine distance out of range");
`endif

endmodule
